FILE: sv/gpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO port register package
// Register codes, access codes, lock sequence states and the bit-spreading
// helpers that are shared by the GPIO port register block.
// ----------------------------------------------------------------------------
package gpr_pkg;

  typedef enum logic {
    CmdRead  = 1'b0,
    CmdWrite = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    RegMode  = 4'd0,
    RegOtype = 4'd1,
    RegSpeed = 4'd2,
    RegPull  = 4'd3,
    RegIdr   = 4'd4,
    RegOdr   = 4'd5,
    RegBsrr  = 4'd6,
    RegLock  = 4'd7,
    RegAfl   = 4'd8,
    RegAfh   = 4'd9
  } reg_index_e;

  typedef enum logic [1:0] {
    LockIdle    = 2'd0,
    LockArmed   = 2'd1,
    LockCleared = 2'd2
  } lock_step_e;

  // A write request to the lock register.
  typedef struct packed {
    logic        wr;
    logic        key;
    logic [15:0] mask;
  } lock_req_t;

  // Lock state as seen by the register file.
  typedef struct packed {
    logic        key;
    logic        key_next;
    logic [15:0] mask;
  } lock_status_t;

  // Widen each pin bit to a 2-bit field.
  function automatic logic [31:0] spread2(logic [15:0] bits);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i +: 2] = {2{bits[i]}};
    end
    return r;
  endfunction

  // Widen each of eight pin bits to a 4-bit field.
  function automatic logic [31:0] spread4(logic [7:0] bits);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = {4{bits[i]}};
    end
    return r;
  endfunction

  // Update a register, keeping frozen bits and forcing absent pins to zero.
  function automatic logic [31:0] merge(logic [31:0] old, logic [31:0] data,
                                        logic [31:0] valid, logic [31:0] frozen);
    return ((old & frozen) | (data & valid & ~frozen)) & valid;
  endfunction

endpackage

FILE: sv/gpr_lock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO lock sequencer
// Tracks the 1, 0, 1 key sequence on the lock register and holds the lock
// mask and the lock key.
// ----------------------------------------------------------------------------
module gpr_lock import gpr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lock_req_t    req_i,
  output lock_status_t status_o
);

  lock_step_e  step_q, step_d;
  logic        key_q, key_d;
  logic [15:0] mask_q, mask_d;
  logic        same;

  assign same = (req_i.mask == mask_q);

  // Next sequence step.
  always_comb begin
    step_d = step_q;
    if (req_i.wr && !key_q) begin
      unique case (step_q)
        LockArmed: begin
          if (!req_i.key && same) step_d = LockCleared;
          else                    step_d = req_i.key ? LockArmed : LockIdle;
        end
        LockCleared: begin
          if (req_i.key && same) step_d = LockIdle;
          else                   step_d = req_i.key ? LockArmed : LockIdle;
        end
        default: begin
          step_d = req_i.key ? LockArmed : LockIdle;
        end
      endcase
    end
  end

  // Key and mask updates.
  always_comb begin
    key_d  = key_q;
    mask_d = mask_q;
    if (req_i.wr && !key_q) begin
      mask_d = req_i.mask;
      if (step_q == LockCleared && req_i.key && same) key_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= LockIdle;
      key_q  <= 1'b0;
      mask_q <= '0;
    end else begin
      step_q <= step_d;
      key_q  <= key_d;
      mask_q <= mask_d;
    end
  end

  assign status_o.key      = key_q;
  assign status_o.key_next = key_d;
  assign status_o.mask     = mask_q;

  a_key_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_q |=> key_q) else $error("lock key cleared without reset");

  a_mask_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_q |=> $stable(mask_q)) else $error("lock mask changed while locked");

  a_step_idle_locked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_q |-> step_q == LockIdle) else $error("lock sequence running while locked");

  a_key_needs_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(key_q) |-> $past(step_q) == LockCleared)
    else $error("lock key set outside of the key sequence");

endmodule

FILE: sv/gpr_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO register file
// Holds the configuration and output data registers, applies one access per
// cycle and forms the read data.
// ----------------------------------------------------------------------------
module gpr_regfile import gpr_pkg::*; #(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         exec_i,
  input  logic         command_i,
  input  logic [3:0]   reg_index_i,
  input  logic [31:0]  write_data_i,
  input  logic [15:0]  pin_levels_i,
  input  lock_status_t lock_i,
  output lock_req_t    lock_req_o,
  output logic [31:0]  read_data_o,
  output logic [15:0]  output_next_o
);

  localparam logic [16:0] PinsWide = (17'd1 << PIN_COUNT) - 17'd1;
  localparam logic [15:0] Pins     = PinsWide[15:0];

  logic [31:0] mode_q, mode_d;
  logic [15:0] otype_q, otype_d;
  logic [31:0] speed_q, speed_d;
  logic [31:0] pull_q, pull_d;
  logic [15:0] odr_q, odr_d;
  logic [31:0] afl_q, afl_d;
  logic [31:0] afh_q, afh_d;

  logic [15:0] frozen;
  logic        is_write;
  reg_index_e  idx;

  assign frozen   = lock_i.key ? lock_i.mask : '0;
  assign is_write = (cmd_e'(command_i) == CmdWrite);
  assign idx      = reg_index_e'(reg_index_i);

  always_comb begin
    mode_d  = mode_q;
    otype_d = otype_q;
    speed_d = speed_q;
    pull_d  = pull_q;
    odr_d   = odr_q;
    afl_d   = afl_q;
    afh_d   = afh_q;
    lock_req_o.wr   = 1'b0;
    lock_req_o.key  = write_data_i[16];
    lock_req_o.mask = write_data_i[15:0] & Pins;
    if (exec_i && is_write) begin
      unique case (idx)
        RegMode:  mode_d  = merge(mode_q, write_data_i, spread2(Pins), spread2(frozen));
        RegOtype: otype_d = 16'(merge({16'd0, otype_q}, write_data_i, {16'd0, Pins},
                                      {16'd0, frozen}));
        RegSpeed: speed_d = merge(speed_q, write_data_i, spread2(Pins), spread2(frozen));
        RegPull:  pull_d  = merge(pull_q, write_data_i, spread2(Pins), spread2(frozen));
        RegOdr:   odr_d   = write_data_i[15:0] & Pins;
        // Set bits win over clear bits.
        RegBsrr:  odr_d   = ((odr_q & ~write_data_i[31:16]) | write_data_i[15:0]) & Pins;
        RegLock:  lock_req_o.wr = 1'b1;
        RegAfl:   afl_d   = merge(afl_q, write_data_i, spread4(Pins[7:0]),
                                  spread4(frozen[7:0]));
        RegAfh:   afh_d   = merge(afh_q, write_data_i, spread4(Pins[15:8]),
                                  spread4(frozen[15:8]));
        default: ;
      endcase
    end
  end

  always_comb begin
    read_data_o = '0;
    if (!is_write) begin
      unique case (idx)
        RegMode:  read_data_o = mode_q;
        RegOtype: read_data_o = {16'd0, otype_q};
        RegSpeed: read_data_o = speed_q;
        RegPull:  read_data_o = pull_q;
        RegIdr:   read_data_o = {16'd0, pin_levels_i & Pins};
        RegOdr:   read_data_o = {16'd0, odr_q};
        RegLock:  read_data_o = {15'd0, lock_i.key, lock_i.mask};
        RegAfl:   read_data_o = afl_q;
        RegAfh:   read_data_o = afh_q;
        default:  read_data_o = '0;
      endcase
    end
  end

  assign output_next_o = odr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      otype_q <= '0;
      speed_q <= '0;
      pull_q  <= '0;
      odr_q   <= '0;
      afl_q   <= '0;
      afh_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      otype_q <= otype_d;
      speed_q <= speed_d;
      pull_q  <= pull_d;
      odr_q   <= odr_d;
      afl_q   <= afl_d;
      afh_q   <= afh_d;
    end
  end

endmodule

FILE: sv/gpio_port_register_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO port register block
// Sixteen-pin GPIO port registers with atomic set/reset and a keyed
// configuration lock, driven by one register access request per cycle while responses flow.
// ----------------------------------------------------------------------------
// Each request is one register access (read or write) together with the
// sampled pin levels, and each request yields exactly one response carrying
// the read data, the output data latch after the access and the lock state.
// A request waits in the input register until the response register is free,
// is applied by the register file as it moves on, and then waits in the
// response register until taken; the block accepts a new request every cycle
// while responses keep flowing, so throughput is one request per cycle. Reads
// return zero for write-only and unknown registers, and writes to read-only
// or unknown registers are dropped. Writing 1, 0, 1 to bit 16 of the lock
// register with an unchanged mask activates the lock; after that the lock
// register ignores writes and the configuration fields of masked pins hold
// their values until reset. Pins at or above PIN_COUNT always read as zero.
// ----------------------------------------------------------------------------
module gpio_port_register_block import gpr_pkg::*; #(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  input  logic [15:0] pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic [15:0] output_levels_o,
  output logic        lock_active_o
);

  // Input register holding the accepted request.
  logic        in_valid_q, in_valid_d;
  logic        command_q;
  logic [3:0]  reg_index_q;
  logic [31:0] write_data_q;
  logic [15:0] pin_levels_q;

  // Response register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] read_data_q;
  logic [15:0] output_levels_q;
  logic        lock_active_q;

  logic         out_free;
  logic         advance;
  logic         accept;
  logic [31:0]  read_data;
  logic [15:0]  output_next;
  lock_req_t    lock_req;
  lock_status_t lock_status;

  // The response slot frees up when empty or when its response is taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept)       in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) out_valid_d = advance;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      command_q    <= command_i;
      reg_index_q  <= reg_index_i;
      write_data_q <= write_data_i;
      pin_levels_q <= pin_levels_i;
    end
    if (advance) begin
      read_data_q     <= read_data;
      output_levels_q <= output_next;
      lock_active_q   <= lock_status.key_next;
    end
  end

  gpr_regfile #(
    .PIN_COUNT (PIN_COUNT)
  ) u_regfile (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .exec_i        (advance),
    .command_i     (command_q),
    .reg_index_i   (reg_index_q),
    .write_data_i  (write_data_q),
    .pin_levels_i  (pin_levels_q),
    .lock_i        (lock_status),
    .lock_req_o    (lock_req),
    .read_data_o   (read_data),
    .output_next_o (output_next)
  );

  gpr_lock u_lock (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (lock_req),
    .status_o (lock_status)
  );

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = read_data_q;
  assign output_levels_o = output_levels_q;
  assign lock_active_o   = lock_active_q;

  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q) else $error("stall without a held request");

  a_resp_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(read_data_q))
    else $error("stalled response was lost or changed");

  a_lock_write_only_on_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_req.wr |-> advance) else $error("lock update without an executing request");

endmodule

FILE: verif/tb_gpio_port_register_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO port register block testbench
// Drives register access requests into the port block, tracks the registers
// in a shadow copy and checks every response field against it. Both sides
// pause at random, except for one calm stretch in the middle of the run.
// ----------------------------------------------------------------------------
module tb_gpio_port_register_block;
  import gpr_pkg::*;

  localparam int unsigned PINS = 16;
  // Cycles without any request or response accepted before the run is given up.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Cycles allowed after the last response for anything stray to show up.
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam logic [15:0] PRESENT_PINS = (PINS >= 16) ? 16'hFFFF : 16'((1 << PINS) - 1);

  // One register access request as it goes into the block.
  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  index;
    logic [31:0] data;
    logic [15:0] pins;
  } gpio_access_t;

  // One response as it comes out of the block.
  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] output_levels;
    logic        lock_active;
  } gpio_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Request side: the payload register and its valid, driven by the driver.
  logic         req_valid = 1'b0;
  gpio_access_t req = '0;
  logic         in_stall_o;

  // Response side.
  logic        out_valid_o;
  logic        resp_stall = 1'b0;
  logic [31:0] read_data_o;
  logic [15:0] output_levels_o;
  logic        lock_active_o;

  gpio_access_t pending_q[$];
  gpio_resp_t   expected_q[$];

  int unsigned cycle_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;

  // Shadow copy of the port registers.
  logic [31:0] cfg_mode;
  logic [15:0] pin_otype;
  logic [31:0] pin_speed;
  logic [31:0] cfg_pull;
  logic [15:0] odr_latch;
  logic [31:0] af_low;
  logic [31:0] af_high;
  logic [15:0] lock_pins;
  logic        lock_set;
  lock_step_e  lock_phase;

  gpio_port_register_block #(
    .PIN_COUNT(PINS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_valid),
    .in_stall_o     (in_stall_o),
    .command_i      (req.cmd),
    .reg_index_i    (req.index),
    .write_data_i   (req.data),
    .pin_levels_i   (req.pins),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (resp_stall),
    .read_data_o    (read_data_o),
    .output_levels_o(output_levels_o),
    .lock_active_o  (lock_active_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow register model
  // --------------------------------------------------------------------------

  // Each pin bit becomes a 2-bit field.
  function automatic logic [31:0] widen2(logic [15:0] bits);
    logic [31:0] w;
    w = '0;
    for (int p = 0; p < 16; p++) begin
      if (bits[p]) w[2*p +: 2] = 2'b11;
    end
    return w;
  endfunction

  // Each of eight pin bits becomes a 4-bit field.
  function automatic logic [31:0] widen4(logic [7:0] bits);
    logic [31:0] w;
    w = '0;
    for (int p = 0; p < 8; p++) begin
      if (bits[p]) w[4*p +: 4] = 4'hF;
    end
    return w;
  endfunction

  // Writable bits take the new data unless they belong to a locked pin.
  function automatic logic [31:0] masked_update(logic [31:0] old_val, logic [31:0] data,
                                                logic [31:0] writable, logic [31:0] held);
    return writable & ((old_val & held) | (data & ~held));
  endfunction

  // Applies one accepted access to the shadow registers and returns the
  // response the block must give for it.
  function automatic gpio_resp_t predict_access(gpio_access_t a);
    gpio_resp_t  r;
    logic [15:0] held;
    logic [15:0] new_mask;
    logic        key;
    logic        same;
    held = lock_set ? lock_pins : 16'h0;
    r = '0;
    if (a.cmd == CmdWrite) begin
      case (a.index)
        RegMode:  cfg_mode = masked_update(cfg_mode, a.data, widen2(PRESENT_PINS), widen2(held));
        RegOtype: pin_otype = PRESENT_PINS & ((pin_otype & held) | (a.data[15:0] & ~held));
        RegSpeed: pin_speed = masked_update(pin_speed, a.data, widen2(PRESENT_PINS), widen2(held));
        RegPull:  cfg_pull = masked_update(cfg_pull, a.data, widen2(PRESENT_PINS), widen2(held));
        RegOdr:   odr_latch = a.data[15:0] & PRESENT_PINS;
        // Set bits win over clear bits for the same pin.
        RegBsrr:  odr_latch = ((odr_latch & ~a.data[31:16]) | a.data[15:0]) & PRESENT_PINS;
        RegLock: begin
          // Once the key is set the lock register no longer listens.
          if (!lock_set) begin
            new_mask = a.data[15:0] & PRESENT_PINS;
            key = a.data[16];
            same = (new_mask == lock_pins);
            if (lock_phase == LockArmed && !key && same) begin
              lock_phase = LockCleared;
            end else if (lock_phase == LockCleared && key && same) begin
              lock_set = 1'b1;
              lock_phase = LockIdle;
            end else begin
              // Anything else aborts; a write with the key bit starts over.
              lock_phase = key ? LockArmed : LockIdle;
            end
            lock_pins = new_mask;
          end
        end
        RegAfl: af_low = masked_update(af_low, a.data, widen4(PRESENT_PINS[7:0]),
                                       widen4(held[7:0]));
        RegAfh: af_high = masked_update(af_high, a.data, widen4(PRESENT_PINS[15:8]),
                                        widen4(held[15:8]));
        default: ;
      endcase
    end else begin
      case (a.index)
        RegMode:  r.read_data = cfg_mode;
        RegOtype: r.read_data = {16'h0, pin_otype};
        RegSpeed: r.read_data = pin_speed;
        RegPull:  r.read_data = cfg_pull;
        RegIdr:   r.read_data = {16'h0, a.pins & PRESENT_PINS};
        RegOdr:   r.read_data = {16'h0, odr_latch};
        RegLock:  r.read_data = {15'h0, lock_set, lock_pins};
        RegAfl:   r.read_data = af_low;
        RegAfh:   r.read_data = af_high;
        default:  r.read_data = '0;
      endcase
    end
    r.output_levels = odr_latch;
    r.lock_active = lock_set;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_access(input cmd_e cmd, input logic [3:0] index,
                              input logic [31:0] data, input logic [15:0] pins);
    gpio_access_t a;
    a.cmd = cmd;
    a.index = index;
    a.data = data;
    a.pins = pins;
    pending_q.push_back(a);
  endtask

  // A random access; lock writes are left out when a sequence is in flight
  // so that filler between steps does not disturb it.
  task automatic queue_random_access(input bit allow_lock);
    logic [3:0]  index;
    logic [31:0] data;
    int unsigned pick;
    index = 4'($urandom_range(0, 15));
    while (!allow_lock && index == RegLock) index = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 9);
    if (pick == 0) data = '0;
    else if (pick == 1) data = '1;
    else data = $urandom;
    queue_access(cmd_e'($urandom_range(0, 1)), index, data, 16'($urandom));
  endtask

  task automatic queue_filler();
    int unsigned n;
    n = $urandom_range(0, 2);
    repeat (n) queue_random_access(1'b0);
  endtask

  // The three-step key sequence. With spoil set, one step has its key bit
  // flipped or its mask changed, so the lock must not engage.
  task automatic queue_lock_sequence(input logic [15:0] mask, input bit spoil);
    int unsigned bad_step;
    bit          flip_key;
    logic [15:0] m;
    logic        key;
    bad_step = $urandom_range(0, 2);
    flip_key = 1'($urandom_range(0, 1));
    for (int s = 0; s < 3; s++) begin
      key = (s != 1);
      m = mask;
      if (spoil && s == bad_step) begin
        if (flip_key) key = ~key;
        else m = mask ^ (16'h1 << $urandom_range(0, 15));
      end
      // The upper data bits are noise the block has to ignore.
      queue_access(CmdWrite, RegLock, {15'($urandom), key, m}, 16'($urandom));
      queue_filler();
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the next pending request once the current one has been
  // taken, and feeds every accepted request to the shadow model.
  // --------------------------------------------------------------------------

  // No pauses in the calm stretch; elsewhere about one cycle in eight.
  function automatic bit calm_stretch();
    return cycle_count >= 800 && cycle_count < 1300;
  endfunction

  function automatic bit side_rests();
    return !calm_stretch() && ($urandom_range(0, 99) < 12);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req <= '0;
    end else begin
      if (req_valid && !in_stall_o) begin
        expected_q.push_back(predict_access(req));
      end
      // The payload only moves once the slot is empty or has just been taken.
      if (!req_valid || !in_stall_o) begin
        if (pending_q.size() > 0 && !side_rests()) begin
          req <= pending_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stalls the response side at random and checks every response
  // taken against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_stall <= 1'b0;
    end else begin
      resp_stall <= side_rests();
      if (out_valid_o && !resp_stall) begin
        if (expected_q.size() == 0) begin
          $error("response without a pending request: read_data %h", read_data_o);
          errors++;
        end else begin
          if (read_data_o !== expected_q[0].read_data) begin
            $error("read_data: expected %h, got %h", expected_q[0].read_data, read_data_o);
            errors++;
          end
          if (output_levels_o !== expected_q[0].output_levels) begin
            $error("output_levels: expected %h, got %h", expected_q[0].output_levels,
                   output_levels_o);
            errors++;
          end
          if (lock_active_o !== expected_q[0].lock_active) begin
            $error("lock_active: expected %b, got %b", expected_q[0].lock_active,
                   lock_active_o);
            errors++;
          end
          void'(expected_q.pop_front());
        end
      end
    end
  end

  // Cycle count for the calm stretch, and the count of cycles in which
  // nothing moved on either channel.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if ((req_valid && !in_stall_o) || (out_valid_o && !resp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("tb_gpio_port_register_block failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] final_mask;

    cfg_mode = '0;
    pin_otype = '0;
    pin_speed = '0;
    cfg_pull = '0;
    odr_latch = '0;
    af_low = '0;
    af_high = '0;
    lock_pins = '0;
    lock_set = 1'b0;
    lock_phase = LockIdle;

    // Directed part. Config registers at full scale, with the unused upper
    // half of the output type word ignored.
    queue_access(CmdWrite, RegMode, '1, 16'h0);
    queue_access(CmdRead, RegMode, '0, 16'h0);
    queue_access(CmdWrite, RegOtype, '1, 16'h0);
    queue_access(CmdRead, RegOtype, '0, 16'h0);
    queue_access(CmdWrite, RegPull, '1, 16'h0);
    queue_access(CmdRead, RegPull, '0, 16'h0);
    queue_access(CmdWrite, RegAfl, '1, 16'h0);
    queue_access(CmdWrite, RegAfh, '1, 16'h0);
    queue_access(CmdRead, RegAfh, '0, 16'h0);
    // Output latch, then set and clear of the same pin: set wins.
    queue_access(CmdWrite, RegOdr, '1, 16'h0);
    queue_access(CmdWrite, RegBsrr, 32'h0003_0001, 16'h0);
    queue_access(CmdRead, RegOdr, '0, 16'h0);
    queue_access(CmdWrite, RegBsrr, 32'hFFFF_0000, 16'h0);
    // Input data is read-only and follows the pins; set/reset reads as zero.
    queue_access(CmdWrite, RegIdr, '1, 16'hFFFF);
    queue_access(CmdRead, RegIdr, '0, 16'hFFFF);
    queue_access(CmdRead, RegIdr, '0, 16'h0);
    queue_access(CmdRead, RegBsrr, '0, 16'hFFFF);
    // Unknown indexes: the write is dropped and the read gives zero.
    queue_access(CmdWrite, 4'd12, '1, 16'h0);
    queue_access(CmdRead, 4'd15, '0, 16'h0);
    // Key written twice restarts the sequence, then a repeated clear step
    // aborts it, so the lock stays open.
    queue_access(CmdWrite, RegLock, 32'h0001_00F0, 16'h0);
    queue_access(CmdWrite, RegLock, 32'h0001_00F0, 16'h0);
    queue_access(CmdWrite, RegLock, 32'h0000_00F0, 16'h0);
    queue_access(CmdWrite, RegLock, 32'h0000_00F0, 16'h0);
    queue_access(CmdRead, RegLock, '0, 16'h0);

    // Random part with the lock open: accesses mixed with broken sequences.
    while (pending_q.size() < 1000) begin
      if ($urandom_range(0, 9) == 0) queue_lock_sequence(16'($urandom), 1'b1);
      else queue_random_access(1'b1);
    end

    // The lock engages only once per run, so it comes late: a full sequence,
    // then every config register hammered at both extremes.
    final_mask = 16'($urandom);
    queue_lock_sequence(final_mask, 1'b0);
    queue_access(CmdRead, RegLock, '0, 16'h0);
    for (int i = 0; i < 2; i++) begin
      queue_access(CmdWrite, RegMode, i ? '0 : '1, 16'h0);
      queue_access(CmdWrite, RegOtype, i ? '0 : '1, 16'h0);
      queue_access(CmdWrite, RegSpeed, i ? '0 : '1, 16'h0);
      queue_access(CmdWrite, RegPull, i ? '0 : '1, 16'h0);
      queue_access(CmdWrite, RegAfl, i ? '0 : '1, 16'h0);
      queue_access(CmdWrite, RegAfh, i ? '0 : '1, 16'h0);
      queue_access(CmdWrite, RegLock, i ? 32'h0001_FFFF : '0, 16'h0);
      queue_access(CmdRead, RegMode, '0, 16'h0);
      queue_access(CmdRead, RegAfh, '0, 16'h0);
      queue_access(CmdRead, RegLock, '0, 16'h0);
    end
    while (pending_q.size() < 1500) begin
      if ($urandom_range(0, 9) == 0) queue_lock_sequence(16'($urandom), 1'($urandom_range(0, 1)));
      else queue_random_access(1'b1);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All requests taken, all responses in, then a short quiet period so a
    // stray response would still be caught.
    while (pending_q.size() > 0 || req_valid) @(posedge clk_i);
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb_gpio_port_register_block passed");
    end else begin
      $display("tb_gpio_port_register_block failed");
    end
    $finish;
  end

endmodule
